FILE: design/fdss_pkg.sv
// Shared types, dictionary table and helpers for the fixed dictionary string scan.
`default_nettype none

package fdss_pkg;

  localparam int NUM_PATTERNS    = 22;
  localparam int MAX_PATTERN_LEN = 21;
  localparam int NAME_LEN_MAX    = 22;
  localparam int NAME_BITS       = NAME_LEN_MAX * 8;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 24;

  typedef logic [7:0]              byte_t;
  typedef logic [NUM_PATTERNS-1:0] mask_t;
  typedef logic [NAME_BITS-1:0]    name_t;

  // Window control from the scan stage to the history register.
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctrl_t;

  // Names are right-aligned: bits [7:0] hold the final character.
  localparam name_t DICT [NUM_PATTERNS] = '{
    "CreateProcessA",
    "CreateProcessInternalA",
    "CreateProcessInternalW",
    "CreateProcessW",
    "GetThreadContext",
    "NtCreateUserProcess",
    "NtGetContextThread",
    "NtResumeThread",
    "NtSetContextThread",
    "NtUnmapViewOfSection",
    "ResumeThread",
    "RtlCreateUserProcess",
    "SetThreadContext",
    "VirtualAllocEx",
    "Wow64GetThreadContext",
    "Wow64SetThreadContext",
    "WriteProcessMemory",
    "ZwCreateUserProcess",
    "ZwGetContextThread",
    "ZwResumeThread",
    "ZwSetContextThread",
    "ZwUnmapViewOfSection"
  };

  localparam int DICT_LEN [NUM_PATTERNS] = '{
    14, 22, 22, 14, 16, 19, 18, 14, 18, 20, 12,
    20, 16, 14, 21, 21, 18, 19, 18, 14, 18, 20
  };

  function automatic byte_t fold_lower(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic name_t fold_name(input name_t s);
    name_t r;
    r = '0;
    for (int i = 0; i < NAME_LEN_MAX; i++) begin
      r[i*8 +: 8] = fold_lower(s[i*8 +: 8]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/fdss_window.sv
// Byte history register: the most recent bytes of the file, newest in slot 0.
`default_nettype none

module fdss_window #(
  parameter int MAX_PATTERN_LEN = fdss_pkg::MAX_PATTERN_LEN
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire fdss_pkg::win_ctrl_t                    ctrl_i,
  input  wire fdss_pkg::byte_t                        byte_i,
  output fdss_pkg::byte_t [MAX_PATTERN_LEN-1:0]       hist_o
);
  import fdss_pkg::*;

  byte_t [MAX_PATTERN_LEN-1:0] hist_r;
  byte_t [MAX_PATTERN_LEN-1:0] hist_nxt;

  always_comb begin
    hist_nxt[0] = byte_i;
    for (int i = 1; i < MAX_PATTERN_LEN; i++) begin
      hist_nxt[i] = hist_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (ctrl_i.clear) begin
      hist_r <= '0;
    end else if (ctrl_i.shift) begin
      hist_r <= hist_nxt;
    end
  end

  assign hist_o = hist_r;

endmodule

`default_nettype wire

FILE: design/fdss_match.sv
// Parallel comparators: every name, exact and lower case, against the window ending now.
`default_nettype none

module fdss_match #(
  parameter int MAX_PATTERN_LEN = fdss_pkg::MAX_PATTERN_LEN
) (
  input  wire fdss_pkg::byte_t                        cur_i,
  input  wire fdss_pkg::byte_t [MAX_PATTERN_LEN-1:0]  hist_i,
  output fdss_pkg::mask_t                             hits_o
);
  import fdss_pkg::*;

  // Position k counts back from the current byte (k = 0).
  byte_t [NAME_LEN_MAX-1:0] tail;

  for (genvar k = 0; k < NAME_LEN_MAX; k++) begin : g_tail
    if (k == 0) begin : g_cur
      assign tail[k] = cur_i;
    end else if (k <= MAX_PATTERN_LEN) begin : g_hist
      assign tail[k] = hist_i[k-1];
    end else begin : g_none
      // Beyond the history: only names too long to ever match reach here.
      assign tail[k] = 8'h00;
    end
  end

  for (genvar p = 0; p < NUM_PATTERNS; p++) begin : g_pat
    localparam name_t EXACT = DICT[p];
    localparam name_t LOWER = fold_name(DICT[p]);
    localparam int    LEN   = DICT_LEN[p];

    logic [NAME_LEN_MAX-1:0] eq_exact;
    logic [NAME_LEN_MAX-1:0] eq_lower;

    for (genvar k = 0; k < NAME_LEN_MAX; k++) begin : g_pos
      if (k < LEN) begin : g_cmp
        assign eq_exact[k] = (tail[k] == EXACT[k*8 +: 8]);
        assign eq_lower[k] = (tail[k] == LOWER[k*8 +: 8]);
      end else begin : g_pad
        assign eq_exact[k] = 1'b1;
        assign eq_lower[k] = 1'b1;
      end
    end

    if (LEN <= MAX_PATTERN_LEN + 1) begin : g_fits
      assign hits_o[p] = (&eq_exact) | (&eq_lower);
    end else begin : g_long
      assign hits_o[p] = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/fixed_dictionary_string_scan.sv
// Top level of the fixed dictionary string scan: input stage, sticky mask and result register.
//
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid / in_tready   | in_tdata[7:0] data_byte, in_tlast last_byte
//  out_    | master    | out_tvalid / out_tready | out_tdata[21:0] found_mask, [22] any_found
//
// One byte per clock while no final byte waits on a stalled result. A single comparator rank lies
// between the input and result registers; a final byte's result shows on out_ once it is registered.
// Reset (synchronous, rst_n low) clears the window, the mask and both valid flags at once.
// While out_tready is low the result holds and bytes before the next final byte keep flowing;
// a final byte then waits in the input register and in_tready drops until the result is taken.
`default_nettype none

module fixed_dictionary_string_scan #(
  parameter int MAX_PATTERN_LEN = fdss_pkg::MAX_PATTERN_LEN
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [fdss_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] data_byte
  input  wire logic                                in_tlast,   // last_byte
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [fdss_pkg::OUT_TDATA_W-1:0]    out_tdata   // [21:0] found_mask, [22] any_found
);
  import fdss_pkg::*;

  logic      stg_valid_r, stg_valid_nxt;
  byte_t     stg_byte_r;
  logic      stg_last_r;
  mask_t     seen_r, seen_nxt;
  logic      out_valid_r, out_valid_nxt;
  mask_t     out_mask_r;
  logic      out_any_r;

  logic      in_acc;
  logic      out_free;
  logic      stg_adv;
  logic      emit;
  mask_t     hits;
  mask_t     final_mask;
  win_ctrl_t win_ctrl;
  byte_t [MAX_PATTERN_LEN-1:0] hist;

  assign out_free  = !out_valid_r || out_tready;
  // Non-final bytes never need the result register.
  assign stg_adv   = stg_valid_r && (!stg_last_r || out_free);
  assign emit      = stg_adv && stg_last_r;
  assign in_tready = !stg_valid_r || stg_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign win_ctrl.shift = stg_adv && !stg_last_r;
  assign win_ctrl.clear = emit;

  fdss_window #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl_i (win_ctrl),
    .byte_i (stg_byte_r),
    .hist_o (hist)
  );

  fdss_match #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_match (
    .cur_i  (stg_byte_r),
    .hist_i (hist),
    .hits_o (hits)
  );

  assign final_mask = seen_r | hits;

  always_comb begin
    stg_valid_nxt = stg_valid_r;
    if (in_acc) begin
      stg_valid_nxt = 1'b1;
    end else if (stg_adv) begin
      stg_valid_nxt = 1'b0;
    end

    seen_nxt = seen_r;
    if (stg_adv) begin
      seen_nxt = stg_last_r ? '0 : final_mask;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      stg_valid_r <= stg_valid_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_byte_r <= in_tdata;
      stg_last_r <= in_tlast;
    end
    if (emit) begin
      out_mask_r <= final_mask;
      out_any_r  <= |final_mask;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_any_r, out_mask_r};

endmodule

`default_nettype wire

FILE: design/fdss_chk.sv
// Port-level checker for the fixed dictionary string scan, bound to the top level.
`default_nettype none

module fdss_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        in_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Flag must agree with the mask it travels with.
  a_any_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[22] == (out_tdata[21:0] != 22'd0)) && !out_tdata[23])
    else $error("any_found disagrees with found_mask");

  // With the result register empty nothing can block the input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input request refused with result register empty");

  // A waiting input request keeps its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable({in_tlast, in_tdata}))
    else $error("input request changed while waiting");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

endmodule

bind fixed_dictionary_string_scan fdss_chk u_fdss_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
